@@ src/vector_distance_engine_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the vector distance engine.
// Each macro expands to a concurrent assertion, or to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef VECTOR_DISTANCE_ENGINE_ASSERT_SVH
`define VECTOR_DISTANCE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define VDE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define VDE_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define VDE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define VDE_ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

@@ src/vde_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector distance engine package
// Shared widths, mode codes and the job record passed from front to back.
// ----------------------------------------------------------------------------
package vde_pkg;
   localparam int ELEM_W  = 16;
   localparam int SUM_W   = 44;
   localparam int DIST_W  = 48;
   localparam int THR_W   = 16;
   localparam int MODE_W  = 2;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [MODE_W-1:0] MODE_L2     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_COSINE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_INNER  = 2'd2;

   localparam logic [THR_W-1:0] THR_RESET = 16'd1;

   typedef struct packed {
      logic [MODE_W-1:0]       mode;
      logic [SUM_W-1:0]        square_diff_sum;
      logic signed [SUM_W-1:0] dot_sum;
      logic [SUM_W-1:0]        norm_a_sum;
      logic [SUM_W-1:0]        norm_b_sum;
   } job_type;

   typedef struct packed {
      logic    push;
      job_type job;
   } push_type;
endpackage

@@ src/vde_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector distance engine channels
// Valid/ready channels for element pairs and for distance results.
// ----------------------------------------------------------------------------
interface vde_req_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               mode;
   logic signed [15:0]       element_a;
   logic signed [15:0]       element_b;
   logic                     last;
   modport source (output valid, mode, element_a, element_b, last, input ready);
   modport sink (input valid, mode, element_a, element_b, last, output ready);
endinterface

interface vde_rsp_if;
   logic                     valid;
   logic                     ready;
   logic signed [47:0]       distance;
   logic                     is_null;
   modport source (output valid, distance, is_null, input ready);
   modport sink (input valid, distance, is_null, output ready);
endinterface

@@ src/vector_distance_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector distance engine
// Streams Q7.8 element pairs and returns an L2, cosine or inner-product distance.
// ----------------------------------------------------------------------------
// The front end takes one element pair per cycle while the queue has room and
// keeps the saturating sums; on the pair marked last it hands the sums to a short
// queue and is ready for the next vector at once unless that queue is full. The
// back end finishes one vector at a time: inner product and null or unused cases
// go straight to the result, L2 takes a 31-step square root, and cosine takes two
// 31-step square roots, one multiply and a 76-step division. The front end stalls
// whenever the queue is full, so a run of short vectors is paced by the back end,
// while long vectors run at one pair per cycle.
module vector_distance_engine #(
   parameter int QUEUE_DEPTH = vde_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [vde_pkg::THR_W-1:0] csr_write_data,
   vde_req_if.sink                   req_chan,
   vde_rsp_if.source                 rsp_chan
);
   import vde_pkg::*;

   push_type push;
   job_type  head;
   logic     full, empty, pop;

   vde_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (full),
      .push_out   (push)
   );

   vde_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_in (push),
      .pop     (pop),
      .full    (full),
      .empty   (empty),
      .head    (head)
   );

   vde_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .queue_empty      (empty),
      .queue_head       (head),
      .queue_pop        (pop),
      .rsp_chan         (rsp_chan)
   );
endmodule

@@ src/vde_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector distance engine front end
// Accepts element pairs, keeps the four saturating sums and queues a job on last.
// ----------------------------------------------------------------------------
module vde_front (
   input  logic              clock,
   input  logic              reset,
   vde_req_if.sink           req_chan,
   input  logic              queue_full,
   output vde_pkg::push_type push_out
);
   import vde_pkg::*;

   logic [SUM_W-1:0]        sd_ff, sd_in, na_ff, na_in, nb_ff, nb_in;
   logic signed [SUM_W-1:0] dot_ff, dot_in;
   logic [MODE_W-1:0]       mode_ff, mode_in;
   logic                    in_vector_ff, in_vector_in;
   logic                    take;
   logic [MODE_W-1:0]       cur_mode;
   logic signed [ELEM_W:0]  diff;
   logic [32:0]             sq_diff;
   logic [31:0]             sq_a, sq_b;
   logic signed [31:0]      prod_ab;
   logic [SUM_W:0]          sd_sum, na_sum, nb_sum;
   logic signed [SUM_W:0]   dot_sum;
   logic [SUM_W-1:0]        sd_sat, na_sat, nb_sat;
   logic signed [SUM_W-1:0] dot_sat;

   assign req_chan.ready = !queue_full;
   assign take = req_chan.valid && req_chan.ready;
   assign cur_mode = in_vector_ff ? mode_ff : req_chan.mode;

   always_comb begin
      diff    = (ELEM_W+1)'(req_chan.element_a) - (ELEM_W+1)'(req_chan.element_b);
      sq_diff = 33'(diff * diff);
      sq_a    = 32'(req_chan.element_a * req_chan.element_a);
      sq_b    = 32'(req_chan.element_b * req_chan.element_b);
      prod_ab = req_chan.element_a * req_chan.element_b;
      sd_sum  = {1'b0, sd_ff} + (SUM_W+1)'(sq_diff);
      na_sum  = {1'b0, na_ff} + (SUM_W+1)'(sq_a);
      nb_sum  = {1'b0, nb_ff} + (SUM_W+1)'(sq_b);
      dot_sum = (SUM_W+1)'(dot_ff) + (SUM_W+1)'(prod_ab);
      sd_sat  = sd_sum[SUM_W] ? {SUM_W{1'b1}} : sd_sum[SUM_W-1:0];
      na_sat  = na_sum[SUM_W] ? {SUM_W{1'b1}} : na_sum[SUM_W-1:0];
      nb_sat  = nb_sum[SUM_W] ? {SUM_W{1'b1}} : nb_sum[SUM_W-1:0];
      if (dot_sum[SUM_W] != dot_sum[SUM_W-1]) begin
         dot_sat = dot_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         dot_sat = dot_sum[SUM_W-1:0];
      end

      sd_in = sd_ff;
      na_in = na_ff;
      nb_in = nb_ff;
      dot_in = dot_ff;
      mode_in = mode_ff;
      in_vector_in = in_vector_ff;
      push_out.push = 1'b0;
      push_out.job.mode = cur_mode;
      push_out.job.square_diff_sum = sd_sat;
      push_out.job.dot_sum = dot_sat;
      push_out.job.norm_a_sum = na_sat;
      push_out.job.norm_b_sum = nb_sat;
      if (take) begin
         if (req_chan.last) begin
            push_out.push = 1'b1;
            sd_in = '0;
            na_in = '0;
            nb_in = '0;
            dot_in = '0;
            in_vector_in = 1'b0;
         end else begin
            sd_in = sd_sat;
            na_in = na_sat;
            nb_in = nb_sat;
            dot_in = dot_sat;
            mode_in = cur_mode;
            in_vector_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sd_ff <= '0;
         na_ff <= '0;
         nb_ff <= '0;
         dot_ff <= '0;
         mode_ff <= '0;
         in_vector_ff <= 1'b0;
      end else begin
         sd_ff <= sd_in;
         na_ff <= na_in;
         nb_ff <= nb_in;
         dot_ff <= dot_in;
         mode_ff <= mode_in;
         in_vector_ff <= in_vector_in;
      end
   end
endmodule

@@ src/vde_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector distance engine job queue
// A short first-in first-out queue of finished sums between front and back.
// ----------------------------------------------------------------------------
module vde_queue #(
   parameter int DEPTH = vde_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  vde_pkg::push_type push_in,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output vde_pkg::job_type  head
);
   import vde_pkg::*;
   `include "vector_distance_engine_assert.svh"

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push_in.push) begin
         mem_ff[wr_ptr_ff] <= push_in.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push_in.push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push_in.push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push_in.push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `VDE_ASSERT_NEVER(a_queue_over, clock, reset, count_ff > CNT_W'(DEPTH))
   `VDE_ASSERT_IMPLIES(a_pop_nonempty, clock, reset, pop, count_ff != '0)
   `VDE_ASSERT_IMPLIES(a_push_room, clock, reset, push_in.push, !full || pop)
endmodule

@@ src/vde_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector distance engine back end
// Turns queued sums into a distance with a shared square root and a divider.
// ----------------------------------------------------------------------------
module vde_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [vde_pkg::THR_W-1:0]  csr_write_data,
   input  logic                       queue_empty,
   input  vde_pkg::job_type           queue_head,
   output logic                       queue_pop,
   vde_rsp_if.source                  rsp_chan
);
   import vde_pkg::*;
   `include "vector_distance_engine_assert.svh"

   localparam int RT_W  = 61;
   localparam int DVD_W = SUM_W + 32;
   localparam int REM_W = 61;
   localparam int DIV_STEPS = DVD_W;

   typedef enum logic [2:0] {ST_IDLE, ST_SQRT, ST_MUL, ST_DIV, ST_DONE} state_type;

   state_type               state_ff, state_in;
   logic [THR_W-1:0]        thr_ff;
   job_type                 job_ff, job_in;
   logic                    phase_ff, phase_in;
   logic [RT_W-1:0]         v_ff, v_in, r_ff, r_in, bit_ff, bit_in;
   logic [29:0]             ra_ff, ra_in;
   logic [59:0]             divisor_ff, divisor_in;
   logic [DVD_W-1:0]        dvd_ff, dvd_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [32:0]             q_ff, q_in;
   logic [6:0]              cnt_ff, cnt_in;
   logic signed [DIST_W-1:0] res_dist_ff, res_dist_in;
   logic                    res_null_ff, res_null_in;
   logic                    out_valid_ff, out_valid_in;
   logic signed [DIST_W-1:0] out_dist_ff, out_dist_in;
   logic                    out_null_ff, out_null_in;

   logic [RT_W-1:0]         sq_t;
   logic [REM_W:0]          rem_sh;
   logic [33:0]             q_next;
   logic [SUM_W-1:0]        mag;
   logic                    is_zero_norm;

   assign rsp_chan.valid    = out_valid_ff;
   assign rsp_chan.distance = out_dist_ff;
   assign rsp_chan.is_null  = out_null_ff;

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      phase_in = phase_ff;
      v_in = v_ff;
      r_in = r_ff;
      bit_in = bit_ff;
      ra_in = ra_ff;
      divisor_in = divisor_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      res_dist_in = res_dist_ff;
      res_null_in = res_null_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_dist_in = out_dist_ff;
      out_null_in = out_null_ff;
      queue_pop = 1'b0;

      sq_t = r_ff + bit_ff;
      rem_sh = {rem_ff, dvd_ff[DVD_W-1]};
      q_next = {q_ff, 1'b0};
      mag = job_ff.dot_sum[SUM_W-1] ? SUM_W'(-job_ff.dot_sum) : SUM_W'(job_ff.dot_sum);
      is_zero_norm = (queue_head.norm_a_sum == '0) || (queue_head.norm_b_sum == '0) ||
                     (queue_head.norm_a_sum < SUM_W'(thr_ff)) ||
                     (queue_head.norm_b_sum < SUM_W'(thr_ff));

      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               queue_pop = 1'b1;
               job_in = queue_head;
               phase_in = 1'b0;
               r_in = '0;
               bit_in = RT_W'(1) << 60;
               res_dist_in = '0;
               res_null_in = 1'b0;
               state_in = ST_DONE;
               case (queue_head.mode)
                  MODE_L2: begin
                     v_in = RT_W'({queue_head.square_diff_sum, 16'd0});
                     state_in = ST_SQRT;
                  end
                  MODE_COSINE: begin
                     if (is_zero_norm) begin
                        res_null_in = 1'b1;
                     end else begin
                        v_in = RT_W'({queue_head.norm_a_sum, 16'd0});
                        state_in = ST_SQRT;
                     end
                  end
                  MODE_INNER: begin
                     res_dist_in = DIST_W'(queue_head.dot_sum);
                  end
                  default: begin
                     res_dist_in = '0;
                  end
               endcase
            end
         end
         ST_SQRT: begin
            if (v_ff >= sq_t) begin
               v_in = v_ff - sq_t;
               r_in = (r_ff >> 1) + bit_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == RT_W'(1)) begin
               if (job_ff.mode == MODE_L2) begin
                  res_dist_in = DIST_W'(r_in);
                  state_in = ST_DONE;
               end else if (!phase_ff) begin
                  ra_in = r_in[29:0];
                  phase_in = 1'b1;
                  v_in = RT_W'({job_ff.norm_b_sum, 16'd0});
                  r_in = '0;
                  bit_in = RT_W'(1) << 60;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            divisor_in = 60'(ra_ff * r_ff[29:0]);
            dvd_in = {mag, 32'd0};
            rem_in = '0;
            q_in = '0;
            cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rem_sh >= (REM_W+1)'(divisor_ff)) begin
               rem_in = REM_W'(rem_sh - (REM_W+1)'(divisor_ff));
               q_next[0] = 1'b1;
            end else begin
               rem_in = REM_W'(rem_sh);
            end
            q_in = (q_next > 34'h1_0000_0000) ? 33'h1_0000_0000 : q_next[32:0];
            dvd_in = dvd_ff << 1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 7'(DIV_STEPS - 1)) begin
               if (job_ff.dot_sum[SUM_W-1]) begin
                  res_dist_in = DIST_W'(65536) + DIST_W'(q_in);
               end else begin
                  res_dist_in = DIST_W'(65536) - DIST_W'(q_in);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in = 1'b1;
               out_dist_in = res_dist_ff;
               out_null_in = res_null_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         thr_ff <= THR_RESET;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            thr_ff <= csr_write_data;
         end
      end
      job_ff <= job_in;
      phase_ff <= phase_in;
      v_ff <= v_in;
      r_ff <= r_in;
      bit_ff <= bit_in;
      ra_ff <= ra_in;
      divisor_ff <= divisor_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      cnt_ff <= cnt_in;
      res_dist_ff <= res_dist_in;
      res_null_ff <= res_null_in;
      out_dist_ff <= out_dist_in;
      out_null_ff <= out_null_in;
   end

   `VDE_ASSERT_IMPLIES(a_div_nonzero, clock, reset, state_ff == ST_DIV, divisor_ff != '0)
   `VDE_ASSERT_IMPLIES(a_pop_idle, clock, reset, queue_pop, state_ff == ST_IDLE)
endmodule
